// File: rtl/sensor_table_find_or_evict_oldest_unit_macros.svh
// Assertion helpers; the using module provides clk and arst_n.
`ifndef SENSOR_TABLE_FIND_OR_EVICT_OLDEST_UNIT_MACROS_SVH
`define SENSOR_TABLE_FIND_OR_EVICT_OLDEST_UNIT_MACROS_SVH

// Same-cycle implication.
`define STFE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define STFE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/stfe_pkg.sv
package stfe_pkg;

	localparam int TABLE_DEPTH  = 32;
	localparam int SERIAL_BYTES = 8;
	localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int KEY_W        = 8 * SERIAL_BYTES;
	localparam int PIN_W        = 5;
	localparam int TEMP_W       = 12;

	typedef enum logic [1:0] {
		MODE_READING   = 2'd0,
		MODE_CLR_ALL   = 2'd1,
		MODE_READ_SLOT = 2'd2,
		MODE_CLR_PIN   = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                     mode;
		logic [PIN_W-1:0]          pin;
		logic [KEY_W-1:0]          key;
		logic [31:0]               sid;
		logic [31:0]               stamp;
		logic                      ok;
		logic signed [TEMP_W-1:0]  temp;
		logic [4:0]                sel;
	} cmd_t;

	typedef struct packed {
		logic [4:0]                slot;
		logic                      matched;
		logic                      occupied;
		logic                      seen;
		logic                      temp_ok;
		logic signed [TEMP_W-1:0]  temp_out;
		logic [31:0]               errors;
		logic [31:0]               id_out;
		logic [PIN_W-1:0]          pin_out;
		logic [63:0]               serial_out;
		logic [31:0]               last_stamp;
	} result_t;

endpackage

// File: rtl/stfe_in_if.sv
interface stfe_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [4:0]         pin;
	logic [63:0]        serial;
	logic [31:0]        sensor_id;
	logic [31:0]        stamp;
	logic               reading_ok;
	logic signed [11:0] celsius;
	logic [4:0]         slot_select;

	modport source (output valid, mode, pin, serial, sensor_id, stamp, reading_ok, celsius,
		slot_select, input ready);
	modport sink (input valid, mode, pin, serial, sensor_id, stamp, reading_ok, celsius,
		slot_select, output ready);
endinterface

// File: rtl/stfe_out_if.sv
interface stfe_out_if;
	logic               valid;
	logic               ready;
	logic [4:0]         slot;
	logic               matched;
	logic               occupied;
	logic               seen;
	logic               temp_ok;
	logic signed [11:0] temp_out;
	logic [31:0]        errors;
	logic [31:0]        id_out;
	logic [4:0]         pin_out;
	logic [63:0]        serial_out;
	logic [31:0]        last_stamp;

	modport source (output valid, slot, matched, occupied, seen, temp_ok, temp_out, errors,
		id_out, pin_out, serial_out, last_stamp, input ready);
	modport sink (input valid, slot, matched, occupied, seen, temp_ok, temp_out, errors,
		id_out, pin_out, serial_out, last_stamp, output ready);
endinterface

// File: rtl/sensor_table_find_or_evict_oldest_unit.sv
// Sequence: a reading event or pin clear is popped, scans the table and ends in a finishing step;
// clear-all and slot read skip the scan and go straight to the finishing step.
// The scan checks one entry per cycle; the back end takes a new command only when idle, after finishing the last.
// Reset: arst_n asynchronous, active low; clears used, present and valid flags and the queue,
// no clearing pass is needed, so the block accepts transactions right after reset.
module sensor_table_find_or_evict_oldest_unit (
	input logic        clk,
	input logic        arst_n,
	stfe_in_if.sink    req,
	stfe_out_if.source rsp
);
	import stfe_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;

	// front: takes transactions, decodes them, buffers two commands
	stfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	// back: table, scan sequencer for find / free / oldest, result register
	stfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp       (rsp)
	);
endmodule

// File: rtl/stfe_front.sv
module stfe_front (
	input  logic           clk,
	input  logic           arst_n,
	stfe_in_if.sink        req,
	output stfe_pkg::cmd_t cmd,
	output logic           cmd_valid,
	input  logic           cmd_ready
);
	import stfe_pkg::*;

	cmd_t       q_mem [2];
	logic [1:0] cnt_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       push;
	logic       pop;
	cmd_t       cls;

	// decode one transaction into a table command
	always_comb begin
		cls.mode  = mode_t'(req.mode);
		cls.pin   = req.pin;
		cls.key   = req.serial[KEY_W-1:0];
		cls.sid   = req.sensor_id;
		cls.stamp = req.stamp;
		cls.ok    = req.reading_ok;
		cls.temp  = req.celsius;
		cls.sel   = req.slot_select;
	end

	assign req.ready = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_mem[rd_ptr_q];
	assign push      = req.valid && req.ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem[wr_ptr_q] <= cls;
	end
endmodule

// File: rtl/stfe_back.sv
`include "sensor_table_find_or_evict_oldest_unit_macros.svh"

module stfe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  stfe_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	stfe_out_if.source     rsp
);
	import stfe_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

	state_t state_q;
	cmd_t   cmd_q;

	logic [TABLE_DEPTH-1:0] used_q;
	logic [TABLE_DEPTH-1:0] present_q;
	logic [TABLE_DEPTH-1:0] valid_q;

	logic [PIN_W-1:0]  pin_mem   [TABLE_DEPTH];
	logic [KEY_W-1:0]  key_mem   [TABLE_DEPTH];
	logic [31:0]       id_mem    [TABLE_DEPTH];
	logic [TEMP_W-1:0] temp_mem  [TABLE_DEPTH];
	logic [31:0]       stamp_mem [TABLE_DEPTH];
	logic [31:0]       err_mem   [TABLE_DEPTH];

	logic [IDX_W-1:0] idx_q;
	logic             hit_q;
	logic             have_free_q;
	logic [IDX_W-1:0] found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [IDX_W-1:0] oldest_q;
	logic [31:0]      oldest_stamp_q;

	logic             out_valid_q;
	result_t          res_q;

	logic [IDX_W-1:0] tgt;
	logic [IDX_W-1:0] rd_idx;
	logic             sel_ok;
	logic             r_used;
	logic             r_pin_eq;
	logic             r_match;
	logic             out_free;
	logic             emit;
	result_t          res;

	assign sel_ok = (32'(cmd_q.sel) < 32'(TABLE_DEPTH));

	always_comb begin
		if (cmd_q.mode == MODE_READ_SLOT) tgt = IDX_W'(cmd_q.sel);
		else if (hit_q) tgt = found_q;
		else if (have_free_q) tgt = free_idx_q;
		else tgt = oldest_q;
	end

	assign rd_idx   = (state_q == ST_SCAN) ? idx_q : tgt;
	assign r_used   = used_q[rd_idx];
	assign r_pin_eq = (pin_mem[rd_idx] == cmd_q.pin);
	assign r_match  = r_used && r_pin_eq && (key_mem[rd_idx] == cmd_q.key);
	assign out_free = !out_valid_q || rsp.ready;
	assign emit     = (state_q == ST_FINISH) && out_free;
	assign cmd_ready = (state_q == ST_IDLE);

	// result of the finishing step; an entry updated by a reading is shown after update
	always_comb begin
		res = '0;
		unique case (cmd_q.mode)
			MODE_READING: begin
				res.slot       = 5'(tgt);
				res.matched    = hit_q;
				res.occupied   = 1'b1;
				res.seen       = 1'b1;
				res.temp_ok    = cmd_q.ok;
				res.temp_out   = cmd_q.ok ? cmd_q.temp
					: (hit_q ? TEMP_W'(temp_mem[rd_idx]) : '0);
				res.errors     = cmd_q.ok ? (hit_q ? err_mem[rd_idx] : 32'd0)
					: (hit_q ? err_mem[rd_idx] + 32'd1 : 32'd1);
				res.id_out     = hit_q ? id_mem[rd_idx] : cmd_q.sid;
				res.pin_out    = cmd_q.pin;
				res.serial_out = 64'(cmd_q.key);
				res.last_stamp = cmd_q.stamp;
			end
			MODE_READ_SLOT: begin
				res.slot = cmd_q.sel;
				if (sel_ok && r_used) begin
					res.occupied   = 1'b1;
					res.seen       = present_q[rd_idx];
					res.temp_ok    = valid_q[rd_idx];
					res.temp_out   = temp_mem[rd_idx];
					res.errors     = err_mem[rd_idx];
					res.id_out     = id_mem[rd_idx];
					res.pin_out    = pin_mem[rd_idx];
					res.serial_out = 64'(key_mem[rd_idx]);
					res.last_stamp = stamp_mem[rd_idx];
				end
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			used_q         <= '0;
			present_q      <= '0;
			valid_q        <= '0;
			idx_q          <= '0;
			hit_q          <= 1'b0;
			have_free_q    <= 1'b0;
			found_q        <= '0;
			free_idx_q     <= '0;
			oldest_q       <= '0;
			oldest_stamp_q <= '1;
			out_valid_q    <= 1'b0;
		end else begin
			if (emit) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						idx_q          <= '0;
						hit_q          <= 1'b0;
						have_free_q    <= 1'b0;
						oldest_q       <= '0;
						oldest_stamp_q <= '1;
						if (cmd.mode == MODE_READING || cmd.mode == MODE_CLR_PIN)
							state_q <= ST_SCAN;
						else
							state_q <= ST_FINISH;
					end
				end
				ST_SCAN: begin
					if (cmd_q.mode == MODE_CLR_PIN) begin
						if (r_used && r_pin_eq) present_q[idx_q] <= 1'b0;
					end else if (!hit_q) begin
						if (r_match) begin
							hit_q   <= 1'b1;
							found_q <= idx_q;
						end else if (!r_used) begin
							if (!have_free_q) begin
								have_free_q <= 1'b1;
								free_idx_q  <= idx_q;
							end
						end else if (stamp_mem[idx_q] < oldest_stamp_q) begin
							oldest_q       <= idx_q;
							oldest_stamp_q <= stamp_mem[idx_q];
						end
					end
					if (idx_q == IDX_W'(TABLE_DEPTH - 1)) state_q <= ST_FINISH;
					else idx_q <= idx_q + IDX_W'(1);
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (cmd_q.mode == MODE_READING) begin
							used_q[tgt]    <= 1'b1;
							present_q[tgt] <= 1'b1;
							valid_q[tgt]   <= cmd_q.ok;
						end else if (cmd_q.mode == MODE_CLR_ALL) begin
							present_q <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) cmd_q <= cmd;
		if (emit) begin
			res_q <= res;
			if (cmd_q.mode == MODE_READING) begin
				pin_mem[tgt]   <= cmd_q.pin;
				key_mem[tgt]   <= cmd_q.key;
				id_mem[tgt]    <= res.id_out;
				temp_mem[tgt]  <= res.temp_out;
				stamp_mem[tgt] <= cmd_q.stamp;
				err_mem[tgt]   <= res.errors;
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.slot       = res_q.slot;
	assign rsp.matched    = res_q.matched;
	assign rsp.occupied   = res_q.occupied;
	assign rsp.seen       = res_q.seen;
	assign rsp.temp_ok    = res_q.temp_ok;
	assign rsp.temp_out   = res_q.temp_out;
	assign rsp.errors     = res_q.errors;
	assign rsp.id_out     = res_q.id_out;
	assign rsp.pin_out    = res_q.pin_out;
	assign rsp.serial_out = res_q.serial_out;
	assign rsp.last_stamp = res_q.last_stamp;

	`STFE_ASSERT_NXT(a_used_sticky, 1'b1, (used_q & $past(used_q)) == $past(used_q), "entry lost its used flag")
	`STFE_ASSERT_IMP(a_present_used, 1'b1, (present_q & ~used_q) == '0, "present flag on unused entry")
	`STFE_ASSERT_IMP(a_valid_used, 1'b1, (valid_q & ~used_q) == '0, "valid flag on unused entry")
	`STFE_ASSERT_NXT(a_reading_result, emit && cmd_q.mode == MODE_READING, out_valid_q && res_q.occupied && res_q.seen, "reading result not marked in use")
endmodule

// File: bench/sensor_table_find_or_evict_oldest_unit_test.sv
module sensor_table_find_or_evict_oldest_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import stfe_pkg::*;

	logic clk;
	logic arst_n;

	stfe_in_if  req ();
	stfe_out_if rsp ();

	sensor_table_find_or_evict_oldest_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Shadow copy of the sensor table, updated as each transaction is accepted.
	logic        tbl_used   [TABLE_DEPTH];
	logic        tbl_seen   [TABLE_DEPTH];
	logic        tbl_tok    [TABLE_DEPTH];
	logic [4:0]  tbl_pin    [TABLE_DEPTH];
	logic [63:0] tbl_serial [TABLE_DEPTH];
	logic [31:0] tbl_id     [TABLE_DEPTH];
	logic [15:0] tbl_temp   [TABLE_DEPTH];
	logic [31:0] tbl_stamp  [TABLE_DEPTH];
	logic [31:0] tbl_errors [TABLE_DEPTH];

	result_t expected_rsp [$];
	int      mismatches;
	int      send_idle_pct;
	int      recv_stall_pct;

	// Pool of keys reused so that hits, evictions and pin clears really happen.
	logic [4:0]  key_pin    [16];
	logic [63:0] key_serial [16];

	function automatic result_t slot_view(int s, logic hit);
		result_t r;
		r.slot       = s[4:0];
		r.matched    = hit;
		r.occupied   = tbl_used[s];
		r.seen       = tbl_seen[s];
		r.temp_ok    = tbl_tok[s];
		r.temp_out   = tbl_temp[s][11:0];
		r.errors     = tbl_errors[s];
		r.id_out     = tbl_id[s];
		r.pin_out    = tbl_pin[s];
		r.serial_out = tbl_serial[s];
		r.last_stamp = tbl_stamp[s];
		return r;
	endfunction

	// Apply one transaction to the shadow table and return the response it should give.
	function automatic result_t table_update(cmd_t c);
		result_t r;
		logic    hit;
		logic    have_free;
		int      found;
		int      free_idx;
		int      oldest;
		int      s;
		r = '0;
		hit = 1'b0;
		have_free = 1'b0;
		found = 0;
		free_idx = 0;
		oldest = 0;
		case (c.mode)
			MODE_READING: begin
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (tbl_used[i] && tbl_pin[i] == c.pin && tbl_serial[i] == c.key) begin
						hit = 1'b1;
						found = i;
						break;
					end
					if (!tbl_used[i]) begin
						if (!have_free) begin
							have_free = 1'b1;
							free_idx = i;
						end
					end else if (tbl_stamp[i] < tbl_stamp[oldest]) begin
						oldest = i;
					end
				end
				if (hit) begin
					s = found;
				end else begin
					s = have_free ? free_idx : oldest;
					tbl_used[s]   = 1'b1;
					tbl_pin[s]    = c.pin;
					tbl_serial[s] = c.key;
					tbl_id[s]     = c.sid;
					tbl_temp[s]   = '0;
					tbl_errors[s] = '0;
				end
				tbl_seen[s]  = 1'b1;
				tbl_stamp[s] = c.stamp;
				tbl_tok[s]   = c.ok;
				if (c.ok) begin
					tbl_temp[s] = {{4{c.temp[11]}}, c.temp};
				end else begin
					tbl_errors[s] = tbl_errors[s] + 32'd1;
				end
				r = slot_view(s, hit);
			end
			MODE_CLR_ALL: begin
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (tbl_used[i]) begin
						tbl_seen[i] = 1'b0;
					end
				end
			end
			MODE_READ_SLOT: begin
				if (c.sel < TABLE_DEPTH) begin
					r = slot_view(c.sel, 1'b0);
				end else begin
					r.slot = c.sel;
				end
			end
			default: begin
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (tbl_used[i] && tbl_pin[i] == c.pin) begin
						tbl_seen[i] = 1'b0;
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s mismatch: got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Send one transaction: drive at the falling edge, wait for acceptance.
	// valid stays high on return so a following transaction can go back to back.
	task automatic send_cmd(cmd_t c);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid       <= 1'b1;
		req.mode        <= c.mode;
		req.pin         <= c.pin;
		req.serial      <= c.key;
		req.sensor_id   <= c.sid;
		req.stamp       <= c.stamp;
		req.reading_ok  <= c.ok;
		req.celsius     <= c.temp;
		req.slot_select <= c.sel;
		do begin
			@(posedge clk);
		end while (!req.ready);
		expected_rsp.push_back(table_update(c));
		@(negedge clk);
	endtask

	function automatic cmd_t random_cmd(int mode_sel);
		cmd_t c;
		int   k;
		c.mode  = mode_t'(mode_sel);
		k       = $urandom_range(15, 0);
		c.pin   = ($urandom_range(9, 0) < 8) ? key_pin[k] : 5'($urandom);
		c.key   = ($urandom_range(9, 0) < 8) ? key_serial[k] : {$urandom, $urandom};
		c.sid   = $urandom;
		c.stamp = ($urandom_range(9, 0) < 8) ? 32'($urandom_range(5000, 0)) : $urandom;
		c.ok    = $urandom_range(3, 0) != 0;
		c.temp  = ($urandom_range(3, 0) == 0) ? 12'($urandom)
		                                      : 12'($signed($urandom_range(2880, 0)) - 880);
		c.sel   = 5'($urandom);
		return c;
	endfunction

	function automatic cmd_t reading(logic [4:0] p, logic [63:0] k, logic [31:0] st,
			logic ok, logic [11:0] t);
		cmd_t c;
		c       = '0;
		c.mode  = MODE_READING;
		c.pin   = p;
		c.key   = k;
		c.sid   = {k[31:0] ^ 32'hA5A5_0000} + st;
		c.stamp = st;
		c.ok    = ok;
		c.temp  = t;
		return c;
	endfunction

	function automatic cmd_t other(mode_t m, logic [4:0] p, logic [4:0] s);
		cmd_t c;
		c      = '0;
		c.mode = m;
		c.pin  = p;
		c.sel  = s;
		return c;
	endfunction

	// Wait until every expected response has arrived, plus the block's latency.
	task automatic drain;
		req.valid <= 1'b0;
		while (expected_rsp.size() != 0) begin
			@(negedge clk);
		end
		repeat (40) @(negedge clk);
	endtask

	// Response checker: sample at the rising edge, compare field by field.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = '{rsp.slot, rsp.matched, rsp.occupied, rsp.seen, rsp.temp_ok,
				rsp.temp_out, rsp.errors, rsp.id_out, rsp.pin_out, rsp.serial_out,
				rsp.last_stamp};
			if (expected_rsp.size() == 0) begin
				report_mismatch("unexpected response", 64'(got.slot), 64'd0);
			end else begin
				want = expected_rsp.pop_front();
				if (got.slot != want.slot) report_mismatch("slot", got.slot, want.slot);
				if (got.matched != want.matched)
					report_mismatch("matched", got.matched, want.matched);
				if (got.occupied != want.occupied)
					report_mismatch("occupied", got.occupied, want.occupied);
				if (got.seen != want.seen) report_mismatch("seen", got.seen, want.seen);
				if (got.temp_ok != want.temp_ok)
					report_mismatch("temp_ok", got.temp_ok, want.temp_ok);
				if (got.temp_out != want.temp_out)
					report_mismatch("temp_out", got.temp_out, want.temp_out);
				if (got.errors != want.errors)
					report_mismatch("errors", got.errors, want.errors);
				if (got.id_out != want.id_out)
					report_mismatch("id_out", got.id_out, want.id_out);
				if (got.pin_out != want.pin_out)
					report_mismatch("pin_out", got.pin_out, want.pin_out);
				if (got.serial_out != want.serial_out)
					report_mismatch("serial_out", got.serial_out, want.serial_out);
				if (got.last_stamp != want.last_stamp)
					report_mismatch("last_stamp", got.last_stamp, want.last_stamp);
			end
		end
	end

	// Receiver backpressure, changed at the falling edge.
	always @(negedge clk) begin
		rsp.ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
	end

	// Extremes of each field, every mode, and the named corner cases.
	task automatic test_directed;
		send_cmd(reading(5'd0, 64'd0, 32'd0, 1'b1, 12'h800));              // min temp pattern
		send_cmd(reading(5'd31, '1, 32'hFFFF_FFFF, 1'b1, 12'h7FF));        // all-ones key
		send_cmd(reading(5'd31, '1, 32'd100, 1'b0, 12'h000));              // hit, error count
		send_cmd(reading(5'd0, 64'd0, 32'd5, 1'b1, 12'(-880)));            // hit, valid
		send_cmd(reading(5'd7, 64'hA5A5_5A5A_0F0F_F0F0, 32'd9, 1'b1, 12'd2000));
		send_cmd(reading(5'd8, 64'hA5A5_5A5A_0F0F_F0F0, 32'd9, 1'b0, 12'd0)); // same serial
		send_cmd(other(MODE_READ_SLOT, 5'd0, 5'd0));
		send_cmd(other(MODE_READ_SLOT, 5'd0, 5'd31));                       // never written
		send_cmd(other(MODE_CLR_PIN, 5'd31, 5'd0));                         // pin clear
		send_cmd(other(MODE_READ_SLOT, 5'd0, 5'd1));
		send_cmd(other(MODE_CLR_ALL, 5'd0, 5'd0));
		send_cmd(other(MODE_READ_SLOT, 5'd0, 5'd2));
		// fill the table, then evict: stamp 0 looks oldest, ties go to lowest index
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			send_cmd(reading(5'(i), 64'h1000 + i, (i == 20) ? 32'd0 : 32'd50, 1'b1, 12'(i)));
		end
		send_cmd(reading(5'd3, 64'hDEAD_BEEF, 32'd60, 1'b1, 12'd1));    // evicts slot 0 (tie)
		send_cmd(reading(5'd4, 64'hBEEF_DEAD, 32'd60, 1'b0, 12'd1));
		drain();
	endtask

	// Random phase with a given idle profile; readings dominate.
	task automatic test_random(int n, int send_pct, int recv_pct);
		int m;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		for (int i = 0; i < n; i++) begin
			m = $urandom_range(99, 0);
			send_cmd(random_cmd(m < 70 ? 0 : m < 76 ? 1 : m < 90 ? 2 : 3));
			// pause until the table has answered everything
			if (i == n / 2) begin
				drain();
			end
		end
		drain();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		mismatches     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.mode        = '0;
		req.pin         = '0;
		req.serial      = '0;
		req.sensor_id   = '0;
		req.stamp       = '0;
		req.reading_ok  = 1'b0;
		req.celsius     = '0;
		req.slot_select = '0;
		rsp.ready       = 1'b1;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tbl_used[i]   = 1'b0;
			tbl_seen[i]   = 1'b0;
			tbl_tok[i]    = 1'b0;
			tbl_pin[i]    = '0;
			tbl_serial[i] = '0;
			tbl_id[i]     = '0;
			tbl_temp[i]   = '0;
			tbl_stamp[i]  = '0;
			tbl_errors[i] = '0;
		end
		// 16 keys, some sharing a pin, against a 32-slot table; extra random keys force eviction
		for (int i = 0; i < 16; i++) begin
			key_pin[i]    = 5'($urandom_range(3, 0) * 8 + (i % 3));
			key_serial[i] = {$urandom, $urandom};
		end
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(240, 0, 0);
		test_random(230, 82, 0);
		test_random(230, 0, 82);
		test_random(230, 7, 7);

		if (mismatches == 0) begin
			$display("sensor_table_find_or_evict_oldest_unit_test: PASS");
		end else begin
			$display("sensor_table_find_or_evict_oldest_unit_test: FAIL");
		end
		$finish;
	end

	// Watchdog: ~1000 items x (latency + stalls) is well under this.
	initial begin
		#20ms;
		$display("sensor_table_find_or_evict_oldest_unit_test: FAIL");
		$finish;
	end

endmodule
